// File: rtl/core/bgrr_pkg.sv
// package: shared types and constants of the bitmap glyph row renderer
package bgrr_pkg;

    localparam int CMD_W    = 2;
    localparam int ADDR_W   = 12;
    localparam int GIDX_W   = 7;
    localparam int GWID_W   = 7;
    localparam int POS_W    = 11;
    localparam int ROW_W    = 6;
    localparam int COLOR_W  = 24;
    localparam int PIX_W    = 12;
    localparam int HEIGHT_W = 7;
    localparam int BYTE_W   = 8;
    localparam int BIDX_W   = 3;
    localparam int COL_W    = 6;

    localparam logic [CMD_W-1:0] CMD_WRITE_BITMAP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_DESC   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DRAW_ROW     = 2'd2;

    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 7'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DESC,
        ST_FETCH,
        ST_LOAD,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [GWID_W-1:0] width;
    } desc_t;

    typedef struct packed {
        logic [POS_W-1:0]   x;
        logic [PIX_W-1:0]   y;
        logic [COLOR_W-1:0] color;
    } row_info_t;

    typedef struct packed {
        logic             hit;
        logic             flush;
        logic [COL_W-1:0] col;
    } emit_ctl_t;

    typedef struct packed {
        logic take;
        logic flushed;
        logic pend_v;
    } emit_sts_t;

endpackage

// File: rtl/core/bgrr_if.sv
// interfaces: command, configuration and pixel channels
interface bgrr_cmd_if;
    import bgrr_pkg::*;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [ADDR_W-1:0]   address;
    logic [BYTE_W-1:0]   data_byte;
    logic [GIDX_W-1:0]   glyph_index;
    logic [GWID_W-1:0]   glyph_width;
    logic [ADDR_W-1:0]   start_index;
    logic [POS_W-1:0]    x_pos;
    logic [POS_W-1:0]    y_pos;
    logic [ROW_W-1:0]    row;
    logic [COLOR_W-1:0]  color;

    modport source (
        output valid, command, address, data_byte, glyph_index, glyph_width,
               start_index, x_pos, y_pos, row, color,
        input  ready
    );
    modport sink (
        input  valid, command, address, data_byte, glyph_index, glyph_width,
               start_index, x_pos, y_pos, row, color,
        output ready
    );
endinterface

interface bgrr_cfg_if;
    import bgrr_pkg::*;
    logic                valid;
    logic                ready;
    logic [HEIGHT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

interface bgrr_pix_if;
    import bgrr_pkg::*;
    logic                valid;
    logic                ready;
    logic [PIX_W-1:0]    pixel_x;
    logic [PIX_W-1:0]    pixel_y;
    logic [COLOR_W-1:0]  pixel_color;
    logic                last;

    modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
    modport sink (input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface

// File: rtl/core/bgrr_emit.sv
// pixel emitter: one-deep pending pixel and output register, marks the last pixel
module bgrr_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  bgrr_pkg::emit_ctl_t ctl,
    input  bgrr_pkg::row_info_t info,
    output bgrr_pkg::emit_sts_t sts,
    bgrr_pix_if.source          pix
);
    import bgrr_pkg::*;

    logic             out_v_reg;
    logic             pend_v_reg;
    logic [COL_W-1:0] pend_col_reg;
    logic [PIX_W-1:0] px_reg;
    logic [PIX_W-1:0] py_reg;
    logic [COLOR_W-1:0] pc_reg;
    logic             last_reg;

    logic out_free;
    logic take;
    logic load_out;
    logic out_last;
    logic flushed;

    always_comb
    begin
        out_free = !out_v_reg || pix.ready;
        take     = 1'b0;
        load_out = 1'b0;
        out_last = 1'b0;
        flushed  = 1'b0;
        if (ctl.hit)
        begin
            if (!pend_v_reg)
            begin
                take = 1'b1;
            end
            else if (out_free)
            begin
                take     = 1'b1;
                load_out = 1'b1;
            end
        end
        else if (ctl.flush)
        begin
            if (!pend_v_reg)
            begin
                flushed = 1'b1;
            end
            else if (out_free)
            begin
                load_out = 1'b1;
                out_last = 1'b1;
                flushed  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            pend_v_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_v_reg <= 1'b1;
            end
            else if (pix.ready)
            begin
                out_v_reg <= 1'b0;
            end
            if (take)
            begin
                pend_v_reg <= 1'b1;
            end
            else if (load_out)
            begin
                pend_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pend_col_reg <= ctl.col;
        end
        if (load_out)
        begin
            px_reg   <= PIX_W'(info.x) + PIX_W'(pend_col_reg);
            py_reg   <= info.y;
            pc_reg   <= info.color;
            last_reg <= out_last;
        end
    end

    assign sts.take        = take;
    assign sts.flushed     = flushed;
    assign sts.pend_v      = pend_v_reg;
    assign pix.valid       = out_v_reg;
    assign pix.pixel_x     = px_reg;
    assign pix.pixel_y     = py_reg;
    assign pix.pixel_color = pc_reg;
    assign pix.last        = last_reg;

endmodule

// File: rtl/core/bitmap_glyph_row_renderer.sv
// top level: bitmap glyph row renderer with bitmap store and descriptor table
//
// channels: cmd takes one request per handshake (bitmap byte write,
// descriptor write or draw of one glyph row); pix gives one pixel write
// per set bit of the row, scanned msb first, last marks the row's final one;
// cfg writes glyph_height and is always ready.
// draw: reads its descriptor, then the bitmap bytes from a synchronous
// store, one bit scanned per cycle unless a set bit waits on the pending
// pixel. a draw accepts the next request once its row is scanned and
// flushed; an empty row (row at or beyond glyph_height, width 0) once the
// descriptor is decoded.
// a pixel leaves one set bit later than it is found, so its last flag is known.
// reset: control clears, glyph_height returns to 16, store contents stay
// undefined until written.
// stall: with pix held off the scan waits on the pending pixel; cmd stays
// not ready until the row's last pixel sits in the output register.
module bitmap_glyph_row_renderer #(
    parameter int BITMAP_DEPTH    = 4096,
    parameter int GLYPH_COUNT     = 128,
    parameter int MAX_GLYPH_WIDTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    bgrr_cmd_if.sink   cmd,
    bgrr_cfg_if.sink   cfg,
    bgrr_pix_if.source pix
);
    import bgrr_pkg::*;

    localparam int AW  = $clog2(BITMAP_DEPTH);
    localparam int SW  = (AW > 14) ? AW : 14;
    localparam int GW  = $clog2(GLYPH_COUNT);
    localparam int GXW = (GW > GIDX_W) ? GW : GIDX_W;
    localparam logic [GWID_W-1:0] MAXW = GWID_W'(MAX_GLYPH_WIDTH);

    logic [BYTE_W-1:0] bmp_mem [BITMAP_DEPTH];
    desc_t             desc_mem [GLYPH_COUNT];

    state_t              state_reg, state_next;
    logic [HEIGHT_W-1:0] height_reg;
    logic [BYTE_W-1:0]   bmp_rdata_reg;
    desc_t               desc_rdata_reg;
    logic [ROW_W-1:0]    row_reg;
    row_info_t           info_reg;
    logic [SW-1:0]       base_reg;
    logic [BIDX_W-1:0]   last_byte_reg;
    logic [BIDX_W-1:0]   byte_idx_reg;
    logic [BIDX_W-1:0]   bit_idx_reg;
    logic [BYTE_W-1:0]   shift_reg;

    logic              cmd_acc;
    logic [SW-1:0]     wa_full;
    logic [AW-1:0]     bmp_waddr;
    logic [GXW-1:0]    gi_full;
    logic [GW-1:0]     gidx;
    logic              bmp_we;
    logic              desc_we;
    logic              desc_re;
    logic              bmp_re;
    logic [3:0]        rd_off;
    logic [SW-1:0]     ra_full;
    logic [AW-1:0]     bmp_raddr;
    logic [GWID_W-1:0] width_c;
    logic              empty_row;
    logic [BIDX_W-1:0] last_byte_c;
    logic [3:0]        nbytes_c;
    logic [9:0]        row_off_c;
    logic              do_desc;
    logic              do_load;
    logic              do_step;
    logic              next_byte;
    emit_ctl_t         ctl;
    emit_sts_t         sts;

    assign cmd_acc   = cmd.valid && cmd.ready;
    assign wa_full   = SW'(cmd.address);
    assign bmp_waddr = wa_full[AW-1:0];
    assign gi_full   = GXW'(cmd.glyph_index);
    assign gidx      = gi_full[GW-1:0];
    assign bmp_we    = cmd_acc && (cmd.command == CMD_WRITE_BITMAP);
    assign desc_we   = cmd_acc && (cmd.command == CMD_WRITE_DESC);
    assign desc_re   = cmd_acc && (cmd.command == CMD_DRAW_ROW);
    assign ra_full   = base_reg + SW'(rd_off);
    assign bmp_raddr = ra_full[AW-1:0];
    assign cfg.ready = 1'b1;

    // descriptor decode
    always_comb
    begin
        width_c     = (desc_rdata_reg.width > MAXW) ? MAXW : desc_rdata_reg.width;
        empty_row   = (width_c == '0) || (HEIGHT_W'(row_reg) >= height_reg);
        last_byte_c = BIDX_W'((width_c - GWID_W'(1)) >> 3);
        nbytes_c    = 4'(last_byte_c) + 4'd1;
        row_off_c   = 10'(row_reg) * 10'(nbytes_c);
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.ready  = 1'b0;
        bmp_re     = 1'b0;
        rd_off     = '0;
        do_desc    = 1'b0;
        do_load    = 1'b0;
        do_step    = 1'b0;
        next_byte  = 1'b0;
        ctl.hit    = 1'b0;
        ctl.flush  = 1'b0;
        ctl.col    = {byte_idx_reg, bit_idx_reg};
        case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (desc_re)
                begin
                    state_next = ST_DESC;
                end
            end
            ST_DESC:
            begin
                do_desc    = 1'b1;
                state_next = empty_row ? ST_IDLE : ST_FETCH;
            end
            ST_FETCH:
            begin
                bmp_re     = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                do_load    = 1'b1;
                bmp_re     = (last_byte_reg != '0);
                rd_off     = 4'd1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                ctl.hit = shift_reg[BYTE_W-1];
                do_step = !shift_reg[BYTE_W-1] || sts.take;
                if (do_step && (bit_idx_reg == '1))
                begin
                    if (byte_idx_reg == last_byte_reg)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        next_byte = 1'b1;
                        bmp_re    = (byte_idx_reg + BIDX_W'(1)) != last_byte_reg;
                        rd_off    = 4'(byte_idx_reg) + 4'd2;
                    end
                end
            end
            ST_FLUSH:
            begin
                ctl.flush = 1'b1;
                if (sts.flushed)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            height_reg <= HEIGHT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                height_reg <= cfg.data;
            end
        end
    end

    // glyph stores
    always_ff @(posedge clk)
    begin
        if (bmp_we)
        begin
            bmp_mem[bmp_waddr] <= cmd.data_byte;
        end
        if (bmp_re)
        begin
            bmp_rdata_reg <= bmp_mem[bmp_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc_we)
        begin
            desc_mem[gidx] <= '{start: cmd.start_index, width: cmd.glyph_width};
        end
        if (desc_re)
        begin
            desc_rdata_reg <= desc_mem[gidx];
        end
    end

    // row datapath
    always_ff @(posedge clk)
    begin
        if (desc_re)
        begin
            row_reg        <= cmd.row;
            info_reg.x     <= cmd.x_pos;
            info_reg.y     <= PIX_W'(cmd.y_pos) + PIX_W'(cmd.row);
            info_reg.color <= cmd.color;
        end
        if (do_desc)
        begin
            base_reg      <= SW'(desc_rdata_reg.start) + SW'(row_off_c);
            last_byte_reg <= last_byte_c;
        end
        if (do_load)
        begin
            shift_reg    <= bmp_rdata_reg;
            byte_idx_reg <= '0;
            bit_idx_reg  <= '0;
        end
        else if (do_step)
        begin
            bit_idx_reg <= bit_idx_reg + BIDX_W'(1);
            if (next_byte)
            begin
                shift_reg    <= bmp_rdata_reg;
                byte_idx_reg <= byte_idx_reg + BIDX_W'(1);
            end
            else
            begin
                shift_reg <= {shift_reg[BYTE_W-2:0], 1'b0};
            end
        end
    end

    bgrr_emit u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .info  (info_reg),
        .sts   (sts),
        .pix   (pix)
    );

    a_scan_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> byte_idx_reg <= last_byte_reg)
        else $error("scan byte index beyond the row");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ready |-> !sts.pend_v)
        else $error("request taken while a pixel is still pending");

    a_desc_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DESC |-> $past(state_reg) == ST_IDLE)
        else $error("descriptor decode not preceded by a draw request");

    a_hit_taken_or_held: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.hit && !sts.take) |=> (state_reg == ST_SCAN && $stable(shift_reg)))
        else $error("scan moved past a set bit that was not taken");

endmodule
